FILE: hw/rtl/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// shared widths and constants for the vector normaliser
// ----------------------------------------------------------------------------
package vln_pkg;

	localparam int SUM_BITS  = 40;
	localparam int ROOT_BITS = 28;
	localparam int UNIT_BITS = 16;
	localparam int LCNT_BITS = 4;
	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;
	localparam logic [UNIT_BITS-1:0] UNIT_MAX = 16'd16384;

endpackage

FILE: hw/rtl/vector_l2_normalize.sv
// ----------------------------------------------------------------------------
// vector_l2_normalize
// stores an embedding vector word by word and emits it scaled to unit length
// ----------------------------------------------------------------------------
//  channel | signals                                   | beat
//  in      | in_valid, in_stall, elem_*, lanes_in_use, | one word of the vector
//          | final_word                                |
//  out     | out_valid, out_stall, unit_*, lanes_out,  | one normalised word
//          | end_of_run, zero_vector, overflowed       |
//  cfg     | cfg_we, cfg_wdata                         | zero_threshold
//
// loading takes one word per cycle into the word ram while in_stall is low.
// on a final word a bit-serial square root of 28 iterations runs (skipped for
// a zero vector), then each stored word is read from the ram, divided in
// eight parallel lane dividers and registered as one output word. input is
// stalled during the root and the emit pass. reset clears run state and the
// threshold; the ram is never cleared.
// ----------------------------------------------------------------------------
module vector_l2_normalize #(
	parameter int LANES     = 8,
	parameter int MAX_WORDS = 64,
	parameter int ELEM_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [vln_pkg::SUM_BITS-1:0]         cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ELEM_BITS-1:0]          elem_0,
	input  logic signed [ELEM_BITS-1:0]          elem_1,
	input  logic signed [ELEM_BITS-1:0]          elem_2,
	input  logic signed [ELEM_BITS-1:0]          elem_3,
	input  logic signed [ELEM_BITS-1:0]          elem_4,
	input  logic signed [ELEM_BITS-1:0]          elem_5,
	input  logic signed [ELEM_BITS-1:0]          elem_6,
	input  logic signed [ELEM_BITS-1:0]          elem_7,
	input  logic [3:0]                           lanes_in_use,
	input  logic                                 final_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [15:0]                   unit_0,
	output logic signed [15:0]                   unit_1,
	output logic signed [15:0]                   unit_2,
	output logic signed [15:0]                   unit_3,
	output logic signed [15:0]                   unit_4,
	output logic signed [15:0]                   unit_5,
	output logic signed [15:0]                   unit_6,
	output logic signed [15:0]                   unit_7,
	output logic [3:0]                           lanes_out,
	output logic                                 end_of_run,
	output logic                                 zero_vector,
	output logic                                 overflowed
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_BITS = $clog2(MAX_WORDS + 1);
	localparam int RW = LANES * ELEM_BITS + vln_pkg::LCNT_BITS;
	localparam int SQ_BITS = 2 * ELEM_BITS;
	localparam int ACC_BITS = (SQ_BITS + 3 > vln_pkg::SUM_BITS) ? SQ_BITS + 3
		: vln_pkg::SUM_BITS;

	typedef enum logic [2:0] {
		S_LOAD, S_ROOT, S_READ, S_DIV, S_OUT
	} state_t;

	state_t                               state_q;
	logic [vln_pkg::SUM_BITS-1:0]         thr_q;
	logic [vln_pkg::SUM_BITS-1:0]         sum_q;
	logic [CNT_BITS-1:0]                  loaded_q;
	logic                                 lost_q;
	logic                                 zero_q;
	logic [vln_pkg::ROOT_BITS-1:0]        norm_q;
	logic [CNT_BITS-1:0]                  rd_q;
	logic                                 sq_start_q;
	logic                                 div_start_q;
	logic [vln_pkg::UNIT_BITS-1:0]        unit_q [8];
	logic [3:0]                           lanes_q;
	logic                                 eor_q;

	logic signed [ELEM_BITS-1:0]          elem_in [8];
	logic [3:0]                           lanes_eff;
	logic [RW-1:0]                        wdata;
	logic [RW-1:0]                        rdata;
	logic [ACC_BITS:0]                    sum_add;
	logic [ACC_BITS:0]                    sq_tot;
	logic                                 accept;
	logic                                 store;
	logic                                 sq_done;
	logic [vln_pkg::ROOT_BITS-1:0]        root;
	logic [LANES-1:0]                     div_done;
	logic [vln_pkg::UNIT_BITS-1:0]        div_unit [LANES];

	assign elem_in[0] = elem_0;
	assign elem_in[1] = elem_1;
	assign elem_in[2] = elem_2;
	assign elem_in[3] = elem_3;
	assign elem_in[4] = elem_4;
	assign elem_in[5] = elem_5;
	assign elem_in[6] = elem_6;
	assign elem_in[7] = elem_7;

	assign in_stall = (state_q != S_LOAD);
	assign accept   = in_valid && !in_stall;
	assign store    = accept && (loaded_q < CNT_BITS'(MAX_WORDS));

	always_comb begin
		logic signed [ELEM_BITS-1:0] e;
		logic [SQ_BITS-1:0]          sq;
		lanes_eff = (lanes_in_use == 4'd0) ? 4'd1 : lanes_in_use;
		if (lanes_eff > 4'(LANES))
			lanes_eff = 4'(LANES);
		wdata  = '0;
		sq_tot = '0;
		wdata[RW-1 -: vln_pkg::LCNT_BITS] = lanes_eff;
		for (int i = 0; i < LANES; i++) begin
			e  = (4'(i) < lanes_eff) ? elem_in[i] : '0;
			sq = SQ_BITS'(e * e);
			wdata[i*ELEM_BITS +: ELEM_BITS] = e;
			sq_tot = sq_tot + (ACC_BITS+1)'(sq);
		end
		sum_add = (ACC_BITS+1)'(sum_q) + sq_tot;
	end

	vln_ram #(.WIDTH(RW), .DEPTH(MAX_WORDS)) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (AW'(loaded_q)),
		.wdata (wdata),
		.raddr (AW'(rd_q)),
		.rdata (rdata)
	);

	vln_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.sum    (sum_q),
		.done   (sq_done),
		.root   (root)
	);

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		vln_div #(.ELEM_BITS(ELEM_BITS)) u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start_q),
			.x      (rdata[g*ELEM_BITS +: ELEM_BITS]),
			.norm   (norm_q),
			.done   (div_done[g]),
			.unit   (div_unit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			thr_q       <= '0;
			sum_q       <= '0;
			loaded_q    <= '0;
			lost_q      <= 1'b0;
			zero_q      <= 1'b0;
			rd_q        <= '0;
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			sq_start_q  <= 1'b0;
			div_start_q <= 1'b0;
			if (cfg_we)
				thr_q <= cfg_wdata;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						logic [vln_pkg::SUM_BITS-1:0] ns;
						logic                         nl;
						ns = sum_q;
						nl = lost_q || !store;
						if (store) begin
							ns = (|sum_add[ACC_BITS:vln_pkg::SUM_BITS]) ? vln_pkg::SUM_MAX
								: sum_add[vln_pkg::SUM_BITS-1:0];
							loaded_q <= loaded_q + CNT_BITS'(1);
						end
						sum_q  <= ns;
						lost_q <= nl;
						if (final_word) begin
							zero_q <= (ns <= thr_q);
							rd_q   <= '0;
							if (ns <= thr_q) begin
								norm_q  <= '0;
								state_q <= S_READ;
							end else begin
								sq_start_q <= 1'b1;
								state_q    <= S_ROOT;
							end
						end
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						norm_q  <= root;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// ram data is ready next cycle, dividers latch it then
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end
				S_DIV: begin
					if (!div_start_q && div_done[0]) begin
						for (int i = 0; i < 8; i++)
							unit_q[i] <= (i < LANES && !zero_q) ? div_unit[i] : '0;
						lanes_q   <= rdata[RW-1 -: vln_pkg::LCNT_BITS];
						eor_q     <= (rd_q + CNT_BITS'(1) == loaded_q);
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (eor_q) begin
							sum_q    <= '0;
							loaded_q <= '0;
							lost_q   <= 1'b0;
							state_q  <= S_LOAD;
						end else begin
							rd_q    <= rd_q + CNT_BITS'(1);
							state_q <= S_READ;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign unit_0      = unit_q[0];
	assign unit_1      = unit_q[1];
	assign unit_2      = unit_q[2];
	assign unit_3      = unit_q[3];
	assign unit_4      = unit_q[4];
	assign unit_5      = unit_q[5];
	assign unit_6      = unit_q[6];
	assign unit_7      = unit_q[7];
	assign lanes_out   = lanes_q;
	assign end_of_run  = eor_q;
	assign zero_vector = zero_q;
	assign overflowed  = lost_q;

endmodule

FILE: hw/rtl/vln_ram.sv
// ----------------------------------------------------------------------------
// vln_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module vln_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/vln_sqrt.sv
// ----------------------------------------------------------------------------
// vln_sqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module vln_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [vln_pkg::SUM_BITS-1:0]        sum,
	output logic                                done,
	output logic [vln_pkg::ROOT_BITS-1:0]       root
);

	localparam int NB = 2 * vln_pkg::ROOT_BITS;

	logic [NB-1:0]                    rad_q;
	logic [vln_pkg::ROOT_BITS+1:0]    rem_q;
	logic [vln_pkg::ROOT_BITS-1:0]    root_q;
	logic [4:0]                       cnt_q;
	logic                             busy_q;
	logic [vln_pkg::ROOT_BITS+1:0]    trial;
	logic [vln_pkg::ROOT_BITS+1:0]    rem_sh;

	always_comb begin
		rem_sh = {rem_q[vln_pkg::ROOT_BITS-1:0], rad_q[NB-1 -: 2]};
		trial  = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(vln_pkg::ROOT_BITS - 1);
				rad_q  <= {sum, 16'd0};
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[NB-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[vln_pkg::ROOT_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[vln_pkg::ROOT_BITS-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	assign root = root_q;

endmodule

FILE: hw/rtl/vln_div.sv
// ----------------------------------------------------------------------------
// vln_div
// per-lane restoring divider: trunc((mag << 22) / norm), saturated, signed
// ----------------------------------------------------------------------------
module vln_div #(
	parameter int ELEM_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ELEM_BITS-1:0]         x,
	input  logic [vln_pkg::ROOT_BITS-1:0]       norm,
	output logic                                done,
	output logic [vln_pkg::UNIT_BITS-1:0]       unit
);

	localparam int NUM_BITS = ELEM_BITS + 22;
	localparam int CW = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0]              num_q;
	logic [NUM_BITS-1:0]              quo_q;
	logic [vln_pkg::ROOT_BITS:0]      rem_q;
	logic [vln_pkg::ROOT_BITS-1:0]    den_q;
	logic                             neg_q;
	logic                             busy_q;
	logic [CW-1:0]                    cnt_q;
	logic [ELEM_BITS-1:0]             mag;
	logic [vln_pkg::ROOT_BITS:0]      rem_sh;
	logic [vln_pkg::UNIT_BITS-1:0]    sat;

	always_comb begin
		mag    = x[ELEM_BITS-1] ? ELEM_BITS'(-x) : ELEM_BITS'(x);
		rem_sh = {rem_q[vln_pkg::ROOT_BITS-1:0], num_q[NUM_BITS-1]};
		sat    = (quo_q > NUM_BITS'(vln_pkg::UNIT_MAX)) ? vln_pkg::UNIT_MAX
			: quo_q[vln_pkg::UNIT_BITS-1:0];
		unit   = (den_q == '0) ? '0 : (neg_q ? -sat : sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS - 1);
				num_q  <= {mag, 22'd0};
				quo_q  <= '0;
				rem_q  <= '0;
				den_q  <= norm;
				neg_q  <= x[ELEM_BITS-1];
			end else if (busy_q) begin
				num_q <= {num_q[NUM_BITS-2:0], 1'b0};
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: verif/tb_vector_l2_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector_l2_normalize
// self-checking bench for the streaming l2 vector normaliser
// ----------------------------------------------------------------------------
// A table of short vectors is walked first: extremes, lane-count clipping and
// the zero vector. Random vectors of random length follow, over several
// threshold settings and including overflowing ones. Every input beat goes
// through a local model of the store, the sum of squares, the root and the
// scaling. Each output beat is compared field by field with the oldest
// predicted word.
// ----------------------------------------------------------------------------
module tb_vector_l2_normalize;

	localparam int NLANE    = 8;
	localparam int DEPTH    = 64;
	localparam int WATCHDOG = 20000;

	typedef struct {
		logic signed [15:0] u [NLANE];
		logic [3:0]         lanes;
		logic               eor;
		logic               zero;
		logic               ovf;
	} unit_word_t;

	typedef struct {
		logic signed [15:0] e [NLANE];
		logic [3:0]         lanes;
		logic               fin;
		bit                 typed;
		unit_word_t         want;
	} word_row_t;

	logic clk = 0, arst_n = 1;
	logic cfg_we = 0;
	logic [vln_pkg::SUM_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 0, in_stall;
	logic signed [15:0] elem [NLANE];
	logic [3:0] lanes_in_use = 4'd1;
	logic final_word = 0;
	logic out_valid, out_stall = 1;
	logic signed [15:0] unit [NLANE];
	logic [3:0] lanes_out;
	logic end_of_run, zero_vector, overflowed;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial foreach (elem[i]) elem[i] = '0;

	vector_l2_normalize dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_0(elem[0]), .elem_1(elem[1]), .elem_2(elem[2]), .elem_3(elem[3]),
		.elem_4(elem[4]), .elem_5(elem[5]), .elem_6(elem[6]), .elem_7(elem[7]),
		.lanes_in_use(lanes_in_use), .final_word(final_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.unit_0(unit[0]), .unit_1(unit[1]), .unit_2(unit[2]), .unit_3(unit[3]),
		.unit_4(unit[4]), .unit_5(unit[5]), .unit_6(unit[6]), .unit_7(unit[7]),
		.lanes_out(lanes_out), .end_of_run(end_of_run),
		.zero_vector(zero_vector), .overflowed(overflowed)
	);

	// local copy of the block state
	logic signed [15:0]  stash [DEPTH][NLANE];
	logic [3:0]          stash_lanes [DEPTH];
	logic [vln_pkg::SUM_BITS-1:0] sq_total;
	int                  stash_count;
	bit                  words_lost;
	logic [vln_pkg::SUM_BITS-1:0] threshold;

	unit_word_t expected_words [$];
	int errors = 0, words_sent = 0, words_checked = 0, vectors = 0, ovf_vectors = 0;
	bit calm = 0, long_hold = 0;
	int idle_cycles = 0;

	function automatic longint unsigned int_root(longint unsigned n);
		longint unsigned rem, acc, bitv;
		rem  = n;
		acc  = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= acc + bitv) begin
				rem -= acc + bitv;
				acc  = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	function automatic logic signed [15:0] scale_lane(logic signed [15:0] x,
			longint unsigned norm);
		longint unsigned mag, q;
		mag = (x < 0) ? longint'(-int'(x)) : longint'(x);
		q = (mag << 22) / norm;
		if (q > vln_pkg::UNIT_MAX)
			q = vln_pkg::UNIT_MAX;
		return (x < 0) ? -$signed(16'(q)) : $signed(16'(q));
	endfunction

	// fold one accepted beat into the state; on a final word queue the whole run
	function automatic void normalise_word(word_row_t w);
		int n;
		longint unsigned sq, norm;
		bit z;
		unit_word_t r;
		n = (w.lanes == 0) ? 1 : (w.lanes > NLANE ? NLANE : w.lanes);
		if (stash_count < DEPTH) begin
			for (int i = 0; i < NLANE; i++) begin
				stash[stash_count][i] = (i < n) ? w.e[i] : 16'sd0;
				sq = longint'(int'(stash[stash_count][i]) * int'(stash[stash_count][i]));
				if (longint'(sq_total) > longint'(vln_pkg::SUM_MAX) - sq)
					sq_total = vln_pkg::SUM_MAX;
				else
					sq_total = sq_total + vln_pkg::SUM_BITS'(sq);
			end
			stash_lanes[stash_count] = 4'(n);
			stash_count++;
		end else begin
			words_lost = 1;
		end
		if (!w.fin)
			return;
		z = sq_total <= threshold;
		norm = z ? 0 : int_root(longint'(sq_total) << 16);
		for (int k = 0; k < stash_count; k++) begin
			foreach (r.u[i])
				r.u[i] = z ? 16'sd0 : scale_lane(stash[k][i], norm);
			r.lanes = stash_lanes[k];
			r.eor   = (k == stash_count - 1);
			r.zero  = z;
			r.ovf   = words_lost;
			expected_words.push_back(r);
		end
		vectors++;
		if (words_lost)
			ovf_vectors++;
		sq_total    = 0;
		stash_count = 0;
		words_lost  = 0;
	endfunction

	task automatic send_word(word_row_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			in_valid <= 0;
			@(negedge clk);
		end
		foreach (elem[i])
			elem[i] <= w.e[i];
		lanes_in_use <= w.lanes;
		final_word   <= w.fin;
		in_valid     <= 1;
		do @(posedge clk); while (in_stall);
		normalise_word(w);
		if (w.typed) begin
			void'(expected_words.pop_back());
			expected_words.push_back(w.want);
		end
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_set(logic [vln_pkg::SUM_BITS-1:0] value);
		in_valid <= 0;
		wait (expected_words.size() == 0);
		repeat (60) @(negedge clk);
		cfg_we    <= 1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 0;
		threshold = value;
	endtask

	// receiver: random hold-off per beat, one very long hold when asked
	initial begin
		int n;
		@(negedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, 8);
			if (long_hold) begin
				n = 400;
				long_hold = 0;
			end
			repeat (n) begin
				out_stall <= 1;
				@(negedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			unit_word_t x;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected output beat, lanes_out %0d", $time, lanes_out);
				errors++;
			end else begin
				x = expected_words.pop_front();
				words_checked++;
				foreach (unit[i])
					if (unit[i] !== x.u[i]) begin
						$display("%0t: unit_%0d expected %0d got %0d",
							$time, i, x.u[i], unit[i]);
						errors++;
					end
				if (lanes_out !== x.lanes) begin
					$display("%0t: lanes_out expected %0d got %0d", $time, x.lanes, lanes_out);
					errors++;
				end
				if (end_of_run !== x.eor) begin
					$display("%0t: end_of_run expected %0b got %0b", $time, x.eor, end_of_run);
					errors++;
				end
				if (zero_vector !== x.zero) begin
					$display("%0t: zero_vector expected %0b got %0b",
						$time, x.zero, zero_vector);
					errors++;
				end
				if (overflowed !== x.ovf) begin
					$display("%0t: overflowed expected %0b got %0b", $time, x.ovf, overflowed);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("%0t: timeout, %0d words still expected", $time, expected_words.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic word_row_t mk(logic [3:0] lanes, logic fin,
			logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] fill);
		word_row_t w;
		foreach (w.e[i])
			w.e[i] = fill;
		w.e[0]  = a;
		w.e[1]  = b;
		w.lanes = lanes;
		w.fin   = fin;
		w.typed = 0;
		foreach (w.want.u[i])
			w.want.u[i] = 16'sd0;
		w.want.lanes = lanes;
		w.want.eor   = 1;
		w.want.zero  = 0;
		w.want.ovf   = 0;
		return w;
	endfunction

	function automatic word_row_t rand_word(logic fin, bit tiny);
		word_row_t w;
		w = mk(4'($urandom_range(0, 15)), fin, 16'sd0, 16'sd0, 16'sd0);
		foreach (w.e[i])
			w.e[i] = tiny ? $signed(16'($urandom_range(0, 15)) - 16'sd8) : 16'($urandom);
		return w;
	endfunction

	word_row_t dir_rows [$];

	initial begin
		word_row_t w;
		logic [vln_pkg::SUM_BITS-1:0] settings [6];
		int len, quota;

		sq_total = 0;
		stash_count = 0;
		words_lost = 0;
		threshold = 0;

		// one lane alone: norm equals the element, unit is exactly one
		w = mk(4'd1, 1'b1, 16'sd4096, 16'sd77, -16'sd5);
		w.typed = 1; w.want.u[0] = 16'sd16384; dir_rows.push_back(w);
		// most negative element alone
		w = mk(4'd1, 1'b1, -16'sd32768, 16'sd1, 16'sd1);
		w.typed = 1; w.want.u[0] = -16'sd16384; dir_rows.push_back(w);
		// all zero: zero vector flagged
		w = mk(4'd8, 1'b1, 16'sd0, 16'sd0, 16'sd0);
		w.typed = 1; w.want.zero = 1; dir_rows.push_back(w);
		// lane count zero counts as one lane
		w = mk(4'd0, 1'b1, 16'sd4096, 16'sd300, 16'sd300);
		w.typed = 1; w.want.u[0] = 16'sd16384; w.want.lanes = 4'd1; dir_rows.push_back(w);
		// lane counts above eight are clipped
		dir_rows.push_back(mk(4'd15, 1'b1, 16'sd32767, 16'sd32767, 16'sd32767));
		dir_rows.push_back(mk(4'd9, 1'b1, -16'sd32768, 16'sd32767, -16'sd1));
		// four-word vector with mixed lane counts
		dir_rows.push_back(mk(4'd3, 1'b0, 16'sd32767, -16'sd32768, 16'sd1234));
		dir_rows.push_back(mk(4'd8, 1'b0, -16'sd1, 16'sd1, 16'sd2));
		dir_rows.push_back(mk(4'd5, 1'b0, 16'sd0, 16'sd0, -16'sd32768));
		dir_rows.push_back(mk(4'd2, 1'b1, 16'sd1, -16'sd1, 16'sd9999));
		// tiny and full-scale values over eight lanes: results well below one
		dir_rows.push_back(mk(4'd8, 1'b1, 16'sd1, -16'sd1, 16'sd1));
		dir_rows.push_back(mk(4'd8, 1'b1, 16'sd32767, -16'sd32768, 16'sd32767));

		@(negedge clk);
		arst_n = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		foreach (dir_rows[r])
			send_word(dir_rows[r]);

		settings[0] = vln_pkg::SUM_MAX;
		settings[1] = 40'd0;
		settings[2] = 40'd1 << 32;
		settings[3] = {8'($urandom), 32'($urandom)};
		settings[4] = 40'd1 << 20;
		settings[5] = 40'($urandom_range(0, 4096));
		quota = 70;

		for (int ph = 0; ph < 6; ph++) begin
			drain_and_set(settings[ph]);
			calm = (ph == 3);
			long_hold = (ph == 2);
			for (int sent = 0; sent < quota; ) begin
				if (ph == 1 && sent == 0)
					len = 66;
				else if (ph == 4 && sent == 0)
					len = 64;
				else if (ph == 5 && sent == 0)
					len = 65;
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(9, 20);
				else
					len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++)
					send_word(rand_word(k == len - 1, ph >= 4 && $urandom_range(0, 1)));
				sent += len;
			end
			calm = 0;
		end

		in_valid <= 0;
		wait (expected_words.size() == 0);
		repeat (100) @(posedge clk);
		$display("covered %0d input words in %0d vectors (%0d overflowing), %0d words checked",
			words_sent, vectors, ovf_vectors, words_checked);
		$display("thresholds from zero to full scale, lane counts 0..15, stalls on both sides");
		if (errors == 0 && expected_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
